FILE: rtl/core/clbs_pkg.sv
// Shared types, codes and constant tables for the character-LCD bus sequencer.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package clbs_pkg;

  // Request modes
  localparam logic [2:0] MODE_INIT = 3'd0;
  localparam logic [2:0] MODE_CMD  = 3'd1;
  localparam logic [2:0] MODE_DATA = 3'd2;
  localparam logic [2:0] MODE_POS  = 3'd3;
  localparam logic [2:0] MODE_HEX  = 3'd4;
  localparam logic [2:0] MODE_DEC  = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CFG_BUS4  = 2'd0;
  localparam logic [1:0] CFG_FUNC  = 2'd1;
  localparam logic [1:0] CFG_SHIFT = 2'd2;

  // Waits in microseconds
  localparam logic [15:0] WAIT_POWER_US = 16'd60000;
  localparam logic [15:0] WAIT_SECOND_US = 16'd20000;
  localparam logic [15:0] WAIT_MS_US    = 16'd1000;
  localparam logic [14:0] WAIT_BYTE_US  = 15'd50;

  // Init command words
  localparam logic [7:0] INIT_WAKE8   = 8'h30;
  localparam logic [7:0] INIT_WAKE4   = 8'h03;
  localparam logic [7:0] INIT_BUS4    = 8'h02;
  localparam logic [7:0] FUNC_SET     = 8'h20;
  localparam logic [7:0] SHIFT_SET    = 8'h10;
  localparam logic [7:0] DISPLAY_ON   = 8'h0C;
  localparam logic [7:0] ENTRY_MODE   = 8'h06;
  localparam logic [7:0] CLEAR_DISP   = 8'h01;
  localparam logic [7:0] SET_DDRAM    = 8'h80;
  localparam logic [7:0] ASCII_ZERO   = 8'h30;
  localparam logic [7:0] ASCII_A_M10  = 8'h37;

  // Step numbers inside the init, hex and decimal sequences
  localparam logic [3:0] STEP_BUS4  = 4'd3;
  localparam logic [3:0] STEP_CLEAR = 4'd8;
  localparam logic [3:0] STEP_INIT_END = 4'd9;
  localparam logic [3:0] STEP_HEX_END  = 4'd1;
  localparam logic [3:0] STEP_DEC_END  = 4'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;     // capture request
    logic sub;      // one decimal subtraction step
    logic emit;     // load the output word register
    logic advance;  // move to the next nibble or byte
    logic skip;     // move to the next byte without emitting
  } dp_cmd_t;

  typedef struct packed {
    logic mode_ok;
    logic skip;
    logic need_sub;
    logic out_last;
  } dp_status_t;

  function automatic logic [6:0] line_offset(input logic [1:0] ln);
    logic [6:0] off;
    case (ln)
      2'd0:    off = 7'h00;
      2'd1:    off = 7'h40;
      2'd2:    off = 7'h14;
      default: off = 7'h54;
    endcase
    return off;
  endfunction

  function automatic logic [13:0] dec_weight(input logic [3:0] step);
    logic [13:0] w;
    case (step)
      4'd0:    w = 14'd10000;
      4'd1:    w = 14'd1000;
      4'd2:    w = 14'd100;
      4'd3:    w = 14'd10;
      default: w = 14'd1;
    endcase
    return w;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) c = ASCII_ZERO + {4'h0, d};
    else c = ASCII_A_M10 + {4'h0, d};
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/clbs_ctrl.sv
// Controller state machine for the character-LCD bus sequencer.
// Depends on clbs_pkg; drives commands into clbs_datapath.
`timescale 1ns / 1ps
`default_nettype none

module clbs_ctrl
  import clbs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        if (!status.mode_ok) begin
          state_nxt = ST_IDLE;
        end else if (status.skip) begin
          cmd.skip = 1'b1;
        end else if (status.need_sub) begin
          // peel one decimal weight off the remainder
          cmd.sub = 1'b1;
        end else begin
          cmd.emit  = 1'b1;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (status.out_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.advance = 1'b1;
            state_nxt   = ST_PREP;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/clbs_datapath.sv
// Datapath for the character-LCD bus sequencer: config registers, request
// registers, byte selection, decimal remainder and output word register.
// Depends on clbs_pkg; commanded by clbs_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module clbs_datapath
  import clbs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [4:0]  cfg_wdata,
  input  wire logic [2:0]  in_mode,
  input  wire logic [15:0] in_value,
  input  wire logic [1:0]  in_line,
  input  wire logic [5:0]  in_column,
  input  wire dp_cmd_t     cmd,
  output dp_status_t       status,
  output logic             out_rs,
  output logic [7:0]       out_bus_value,
  output logic [15:0]      out_wait_before_us,
  output logic [14:0]      out_wait_after_us,
  output logic             out_last
);

  logic       bus4_r;
  logic [4:0] func_r;
  logic [3:0] shift_r;

  logic [2:0]  mode_r;
  logic [15:0] value_r;
  logic [1:0]  line_r;
  logic [5:0]  column_r;
  logic [3:0]  step_r;
  logic        phase_r;
  logic [3:0]  digit_r;

  logic [7:0]  byte_sel;
  logic [15:0] before_sel;
  logic        rs_sel;
  logic        lone;
  logic        last_byte;
  logic [6:0]  pos_addr;
  logic [15:0] weight;

  logic        s_rs;
  logic [7:0]  s_bus;
  logic [15:0] s_before;
  logic [14:0] s_after;
  logic        s_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus4_r  <= 1'b1;
      func_r  <= 5'd8;
      shift_r <= 4'd4;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_BUS4:  bus4_r  <= cfg_wdata[0];
        CFG_FUNC:  func_r  <= cfg_wdata;
        CFG_SHIFT: shift_r <= cfg_wdata[3:0];
        default:   ;
      endcase
    end
  end

  assign pos_addr = line_offset(line_r) + {1'b0, column_r} - 7'd1;
  assign weight   = {2'b00, dec_weight(step_r)};

  always_comb begin
    byte_sel   = 8'h00;
    before_sel = 16'd0;
    rs_sel     = 1'b0;
    lone       = 1'b0;
    last_byte  = 1'b0;
    unique case (mode_r)
      MODE_INIT: begin
        lone      = bus4_r && (step_r <= STEP_BUS4);
        last_byte = (step_r == STEP_INIT_END);
        case (step_r)
          4'd0: begin
            byte_sel   = bus4_r ? INIT_WAKE4 : INIT_WAKE8;
            before_sel = WAIT_POWER_US;
          end
          4'd1: begin
            byte_sel   = bus4_r ? INIT_WAKE4 : INIT_WAKE8;
            before_sel = WAIT_SECOND_US;
          end
          4'd2: begin
            byte_sel   = bus4_r ? INIT_WAKE4 : INIT_WAKE8;
            before_sel = WAIT_MS_US;
          end
          STEP_BUS4: byte_sel = INIT_BUS4;
          4'd4: byte_sel = FUNC_SET | {3'b000, func_r};
          4'd5: byte_sel = SHIFT_SET | {4'h0, shift_r};
          4'd6: byte_sel = DISPLAY_ON;
          4'd7: byte_sel = ENTRY_MODE;
          STEP_CLEAR: begin
            byte_sel   = CLEAR_DISP;
            before_sel = WAIT_MS_US;
          end
          default: byte_sel = SET_DDRAM;
        endcase
      end
      MODE_CMD: begin
        byte_sel  = value_r[7:0];
        last_byte = 1'b1;
      end
      MODE_DATA: begin
        byte_sel  = value_r[7:0];
        rs_sel    = 1'b1;
        last_byte = 1'b1;
      end
      MODE_POS: begin
        byte_sel  = SET_DDRAM | {1'b0, pos_addr};
        last_byte = 1'b1;
      end
      MODE_HEX: begin
        byte_sel  = hex_char((step_r == 4'd0) ? value_r[7:4] : value_r[3:0]);
        rs_sel    = 1'b1;
        last_byte = (step_r == STEP_HEX_END);
      end
      MODE_DEC: begin
        byte_sel  = ASCII_ZERO + {4'h0, digit_r};
        rs_sel    = 1'b1;
        last_byte = (step_r == STEP_DEC_END);
      end
      default: ;
    endcase
  end

  // shape the strobe: lone nibble, nibble pair or full byte
  always_comb begin
    s_rs = rs_sel;
    if (lone) begin
      s_bus    = byte_sel;
      s_before = before_sel;
      s_after  = 15'd0;
      s_last   = 1'b0;
    end else if (bus4_r && !phase_r) begin
      s_bus    = {4'h0, byte_sel[7:4]};
      s_before = before_sel;
      s_after  = 15'd0;
      s_last   = 1'b0;
    end else if (bus4_r) begin
      s_bus    = {4'h0, byte_sel[3:0]};
      s_before = 16'd0;
      s_after  = WAIT_BYTE_US;
      s_last   = last_byte;
    end else begin
      s_bus    = byte_sel;
      s_before = before_sel;
      s_after  = WAIT_BYTE_US;
      s_last   = last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      phase_r <= 1'b0;
      digit_r <= '0;
    end else if (cmd.load) begin
      step_r  <= '0;
      phase_r <= 1'b0;
      digit_r <= '0;
    end else if (cmd.sub) begin
      digit_r <= digit_r + 4'd1;
    end else if (cmd.skip) begin
      step_r <= step_r + 4'd1;
    end else if (cmd.advance) begin
      if (bus4_r && !lone && !phase_r) begin
        phase_r <= 1'b1;
      end else begin
        step_r  <= step_r + 4'd1;
        phase_r <= 1'b0;
        digit_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r   <= in_mode;
      value_r  <= in_value;
      line_r   <= in_line;
      column_r <= in_column;
    end else if (cmd.sub) begin
      value_r <= value_r - weight;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_rs             <= s_rs;
      out_bus_value      <= s_bus;
      out_wait_before_us <= s_before;
      out_wait_after_us  <= s_after;
      out_last           <= s_last;
    end
  end

  assign status.mode_ok  = (mode_r <= MODE_DEC);
  assign status.skip     = (mode_r == MODE_INIT) && !bus4_r && (step_r == STEP_BUS4);
  assign status.need_sub = (mode_r == MODE_DEC) && (value_r >= weight);
  assign status.out_last = out_last;

endmodule

`default_nettype wire

FILE: rtl/core/char_lcd_bus_sequencer_top.sv
// Character-LCD bus sequencer: turns one request (init, command, data, cursor
// position, hex byte, five-digit decimal) into a run of bus strobe words, each
// with register select, data lines, wait before and wait after. One request is
// handled at a time. Each strobe is selected in the prepare state, then presented
// in the output state until taken; a 4-bit init is 16 strobes. Decimal requests
// add one subtraction per unit of each digit, since the digits come from a
// repeated-subtract loop on the remainder register. Modes 6 and 7 give no words.
// The user must write config only while idle; the block does not enforce it.
// Depends on clbs_pkg, clbs_ctrl and clbs_datapath.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_bus_sequencer_top
  import clbs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [4:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_mode,
  input  wire logic [15:0] in_value,
  input  wire logic [1:0]  in_line,
  input  wire logic [5:0]  in_column,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_rs,
  output logic [7:0]       out_bus_value,
  output logic [15:0]      out_wait_before_us,
  output logic [14:0]      out_wait_after_us,
  output logic             out_last
);

  dp_cmd_t    cmd;
  dp_status_t status;

  clbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  clbs_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_mode            (in_mode),
    .in_value           (in_value),
    .in_line            (in_line),
    .in_column          (in_column),
    .cmd                (cmd),
    .status             (status),
    .out_rs             (out_rs),
    .out_bus_value      (out_bus_value),
    .out_wait_before_us (out_wait_before_us),
    .out_wait_after_us  (out_wait_after_us),
    .out_last           (out_last)
  );

endmodule

`default_nettype wire

FILE: tb/sv/tb_char_lcd_bus_sequencer_top.sv
// Testbench for char_lcd_bus_sequencer_top: drives requests, predicts every bus strobe word
// and checks the result stream word by word across bus widths, flags and idle patterns.
// Depends on clbs_pkg and the sequencer RTL.
`timescale 1ns / 1ps

module tb_char_lcd_bus_sequencer_top;
  import clbs_pkg::*;

  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT = 3000;
  localparam int LONG_HOLD_CYCLES = 300;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] value;
    logic [1:0]  line;
    logic [5:0]  column;
  } lcd_req_t;

  typedef struct packed {
    logic        rs;
    logic [7:0]  bus;
    logic [15:0] before_us;
    logic [14:0] after_us;
    logic        last;
  } strobe_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [4:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_mode = '0;
  logic [15:0] in_value = '0;
  logic [1:0]  in_line = '0;
  logic [5:0]  in_column = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_rs;
  logic [7:0]  out_bus_value;
  logic [15:0] out_wait_before_us;
  logic [14:0] out_wait_after_us;
  logic        out_last;

  char_lcd_bus_sequencer_top i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_value           (in_value),
    .in_line            (in_line),
    .in_column          (in_column),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_rs             (out_rs),
    .out_bus_value      (out_bus_value),
    .out_wait_before_us (out_wait_before_us),
    .out_wait_after_us  (out_wait_after_us),
    .out_last           (out_last)
  );

  // Mirror of the configuration registers
  logic       bus4_mirror = 1'b1;
  logic [4:0] func_mirror = 5'd8;
  logic [3:0] shift_mirror = 4'd4;

  lcd_req_t pending_requests[$];
  strobe_t  expected_strobes[$];
  lcd_req_t shown_req;
  strobe_t  run_buf[16];
  int       run_len;

  int n_queued = 0;
  int n_taken = 0;
  int n_words = 0;
  int n_errors = 0;
  int n_by_mode[8];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void flag_error(string msg);
    if (n_errors < 10) $display("%0t ERROR: %s", $time, msg);
    n_errors++;
  endfunction

  function automatic void add_strobe(logic rs, logic [7:0] bus, logic [15:0] before_us,
                                     logic [14:0] after_us);
    if (run_len < 16) begin
      run_buf[run_len].rs = rs;
      run_buf[run_len].bus = bus;
      run_buf[run_len].before_us = before_us;
      run_buf[run_len].after_us = after_us;
      run_buf[run_len].last = 1'b0;
      run_len++;
    end
  endfunction

  // A byte is two nibble strobes on a 4-bit bus, one strobe otherwise
  function automatic void add_byte(logic rs, logic [7:0] b, logic [15:0] before_us);
    if (bus4_mirror) begin
      add_strobe(rs, {4'h0, b[7:4]}, before_us, 15'd0);
      add_strobe(rs, {4'h0, b[3:0]}, 16'd0, 15'd50);
    end else begin
      add_strobe(rs, b, before_us, 15'd50);
    end
  endfunction

  function automatic void predict_strobes(lcd_req_t r);
    int unsigned weights[5] = '{10000, 1000, 100, 10, 1};
    int unsigned num;
    logic [6:0] base;
    logic [6:0] addr;
    logic [3:0] d;
    run_len = 0;
    case (r.mode)
      MODE_INIT: begin
        if (bus4_mirror) begin
          add_strobe(1'b0, 8'h03, 16'd60000, 15'd0);
          add_strobe(1'b0, 8'h03, 16'd20000, 15'd0);
          add_strobe(1'b0, 8'h03, 16'd1000, 15'd0);
          add_strobe(1'b0, 8'h02, 16'd0, 15'd0);
        end else begin
          add_byte(1'b0, 8'h30, 16'd60000);
          add_byte(1'b0, 8'h30, 16'd20000);
          add_byte(1'b0, 8'h30, 16'd1000);
        end
        add_byte(1'b0, 8'h20 | {3'b000, func_mirror}, 16'd0);
        add_byte(1'b0, 8'h10 | {4'h0, shift_mirror}, 16'd0);
        add_byte(1'b0, 8'h0C, 16'd0);
        add_byte(1'b0, 8'h06, 16'd0);
        add_byte(1'b0, 8'h01, 16'd1000);
        add_byte(1'b0, 8'h80, 16'd0);
      end
      MODE_CMD:  add_byte(1'b0, r.value[7:0], 16'd0);
      MODE_DATA: add_byte(1'b1, r.value[7:0], 16'd0);
      MODE_POS: begin
        case (r.line)
          2'd0:    base = 7'h00;
          2'd1:    base = 7'h40;
          2'd2:    base = 7'h14;
          default: base = 7'h54;
        endcase
        // column 0 and overlong columns wrap in seven address bits
        addr = base + 7'(r.column) - 7'd1;
        add_byte(1'b0, {1'b1, addr}, 16'd0);
      end
      MODE_HEX: begin
        for (int i = 0; i < 2; i++) begin
          d = (i == 0) ? r.value[7:4] : r.value[3:0];
          add_byte(1'b1, (d < 4'd10) ? 8'h30 + 8'(d) : 8'h37 + 8'(d), 16'd0);
        end
      end
      MODE_DEC: begin
        num = r.value;
        for (int i = 0; i < 5; i++)
          add_byte(1'b1, 8'h30 + 8'((num / weights[i]) % 10), 16'd0);
      end
      default: ;
    endcase
    if (run_len > 0) run_buf[run_len - 1].last = 1'b1;
    for (int i = 0; i < run_len; i++) expected_strobes.push_back(run_buf[i]);
  endfunction

  // Driver: hold the word until taken, then offer the next one or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_strobes(shown_req);
        n_by_mode[shown_req.mode]++;
        n_taken++;
      end
      if (!in_valid || in_ready) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          shown_req = pending_requests.pop_front();
          in_valid <= 1'b1;
          in_mode <= shown_req.mode;
          in_value <= shown_req.value;
          in_line <= shown_req.line;
          in_column <= shown_req.column;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each taken word against the oldest prediction
  always @(posedge clk) begin
    strobe_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_words++;
        if (expected_strobes.size() == 0) begin
          flag_error($sformatf("unexpected word rs=%0d bus=%02h before=%0d after=%0d last=%0d",
                               out_rs, out_bus_value, out_wait_before_us,
                               out_wait_after_us, out_last));
        end else begin
          want = expected_strobes.pop_front();
          if (out_rs !== want.rs || out_bus_value !== want.bus ||
              out_wait_before_us !== want.before_us || out_wait_after_us !== want.after_us ||
              out_last !== want.last)
            flag_error($sformatf({"word mismatch: expected rs=%0d bus=%02h before=%0d ",
                                  "after=%0d last=%0d, got rs=%0d bus=%02h before=%0d ",
                                  "after=%0d last=%0d"},
                                 want.rs, want.bus, want.before_us, want.after_us, want.last,
                                 out_rs, out_bus_value, out_wait_before_us,
                                 out_wait_after_us, out_last));
        end
      end
      if (hold_request) begin
        hold_left = LONG_HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic queue_request(logic [2:0] mode, logic [15:0] value, logic [1:0] line,
                               logic [5:0] column);
    lcd_req_t r;
    r.mode = mode;
    r.value = value;
    r.line = line;
    r.column = column;
    pending_requests.push_back(r);
    n_queued++;
  endtask

  // Spare modes are mixed in but do not count toward the total
  task automatic queue_random(int count);
    int done;
    logic [2:0] mode;
    logic [5:0] column;
    done = 0;
    while (done < count) begin
      if ($urandom_range(99) < 5) begin
        mode = 3'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
      end else begin
        mode = 3'($urandom_range(MODE_DEC, MODE_INIT));
        done++;
      end
      column = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(40, 1));
      queue_request(mode, 16'($urandom), 2'($urandom_range(3)), column);
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (n_taken != n_queued || expected_strobes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, logic [4:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    case (index)
      CFG_BUS4:  bus4_mirror = data[0];
      CFG_FUNC:  func_mirror = data;
      CFG_SHIFT: shift_mirror = data[3:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_config(logic bus4, logic [4:0] func, logic [3:0] shift);
    wait_idle();
    write_reg(CFG_BUS4, {4'h0, bus4});
    write_reg(CFG_FUNC, func);
    write_reg(CFG_SHIFT, {1'b0, shift});
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests on the reset configuration, no idling
    queue_request(MODE_INIT, 16'h0000, 2'd0, 6'd1);
    queue_request(MODE_CMD, 16'h0000, 2'd0, 6'd1);
    queue_request(MODE_CMD, 16'h00FF, 2'd3, 6'd63);
    queue_request(MODE_CMD, 16'hFF00, 2'd0, 6'd1);
    queue_request(MODE_DATA, 16'h0041, 2'd1, 6'd2);
    queue_request(MODE_DATA, 16'hFFFF, 2'd2, 6'd3);
    queue_request(MODE_POS, 16'h0000, 2'd0, 6'd1);
    queue_request(MODE_POS, 16'hFFFF, 2'd1, 6'd40);
    queue_request(MODE_POS, 16'h0000, 2'd2, 6'd20);
    queue_request(MODE_POS, 16'h0000, 2'd3, 6'd40);
    queue_request(MODE_POS, 16'h0000, 2'd3, 6'd63);
    queue_request(MODE_POS, 16'h0000, 2'd0, 6'd0);
    queue_request(MODE_HEX, 16'h0000, 2'd0, 6'd1);
    queue_request(MODE_HEX, 16'h00FF, 2'd0, 6'd1);
    queue_request(MODE_HEX, 16'h009A, 2'd0, 6'd1);
    queue_request(MODE_HEX, 16'hA5F0, 2'd0, 6'd1);
    queue_request(MODE_DEC, 16'd0, 2'd0, 6'd1);
    queue_request(MODE_DEC, 16'd65535, 2'd0, 6'd1);
    queue_request(MODE_DEC, 16'd10009, 2'd0, 6'd1);
    queue_request(MODE_DEC, 16'd9990, 2'd0, 6'd1);
    queue_request(MODE_SPARE_LO, 16'h0000, 2'd0, 6'd0);
    queue_request(MODE_SPARE_HI, 16'hFFFF, 2'd3, 6'd63);
    queue_request(MODE_CMD, 16'h0001, 2'd0, 6'd1);

    // 8-bit bus with all flags set
    set_config(1'b0, 5'd31, 4'd15);
    queue_request(MODE_INIT, 16'h0000, 2'd0, 6'd1);
    queue_random(15);

    // 4-bit bus with no flags, sender mostly idle
    set_config(1'b1, 5'd0, 4'd0);
    send_idle_pct = 61;
    queue_request(MODE_INIT, 16'h0000, 2'd0, 6'd1);
    queue_random(20);

    // receiver mostly stalled
    set_config(1'b0, 5'($urandom_range(31)), 4'($urandom_range(15)));
    send_idle_pct = 0;
    recv_stall_pct = 61;
    queue_random(20);

    // long receiver hold while the sender keeps offering words
    set_config(1'b1, 5'($urandom_range(31)), 4'($urandom_range(15)));
    recv_stall_pct = 0;
    hold_request = 1'b1;
    queue_random(10);

    // light idling on both sides, with a full drain in the middle
    set_config(1'b0, 5'($urandom_range(31)), 4'($urandom_range(15)));
    send_idle_pct = 9;
    recv_stall_pct = 9;
    queue_random(10);
    wait_idle();
    queue_random(10);

    wait_idle();
    repeat (100) @(posedge clk);
    if (expected_strobes.size() != 0)
      flag_error($sformatf("%0d predicted words never arrived", expected_strobes.size()));
    $display("Ran %0d requests: init %0d, command %0d, data %0d, position %0d, hex %0d,",
             n_taken, n_by_mode[MODE_INIT], n_by_mode[MODE_CMD], n_by_mode[MODE_DATA],
             n_by_mode[MODE_POS], n_by_mode[MODE_HEX]);
    $display("decimal %0d, spare %0d; %0d strobe words checked on 4- and 8-bit buses, %0d errors",
             n_by_mode[MODE_DEC], n_by_mode[MODE_SPARE_LO] + n_by_mode[MODE_SPARE_HI],
             n_words, n_errors);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/clbs_pkg.sv
rtl/core/clbs_ctrl.sv
rtl/core/clbs_datapath.sv
rtl/core/char_lcd_bus_sequencer_top.sv
tb/sv/tb_char_lcd_bus_sequencer_top.sv
